FILE: sv/gaci_pkg.sv
// Package with the request types, field width and defaults of the Green-Ampt crust infiltration core.
package gaci_pkg;

  localparam int unsigned FIELD_W = 48;
  localparam int unsigned WORD_BITS_DEF = 48;
  localparam int unsigned FRAC_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RATE  = 1'b0,
    CFG_EARLY_THR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [FIELD_W-1:0] water_depth;
    logic [FIELD_W-1:0] infiltrated_total;
    logic [FIELD_W-1:0] time_step;
    logic [FIELD_W-1:0] crust_conductivity;
    logic [FIELD_W-1:0] soil_conductivity;
    logic [FIELD_W-1:0] moisture_deficit;
    logic [FIELD_W-1:0] suction_head;
    logic [FIELD_W-1:0] crust_thickness;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] infiltrated;
    logic [FIELD_W-1:0] remaining_depth;
  } out_item_t;

endpackage

FILE: sv/green_ampt_crust_infiltration_core.sv
// Top level of the Green-Ampt crust infiltration core: a deep pipeline, one cell per cycle unless the output stalls.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+---------------------------
//   cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | out       | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// A new request is taken every cycle unless the output stalls. The pipeline is made of the
// four chained dividers, WORD_BITS + 1 stages each, the four three-stage multipliers and
// seven single-register stages.
// Reset clears the valid bits of every stage and of the output register, and both configuration
// registers. While a finished result sits unaccepted in the output register and the
// receiver stalls, the whole pipeline holds; in every other cycle it advances, bubbles
// included, so nothing is lost or repeated.
module green_ampt_crust_infiltration_core #(
  parameter int unsigned WORD_BITS = gaci_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = gaci_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gaci_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gaci_pkg::FIELD_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gaci_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gaci_pkg::out_item_t               out_data_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned FW = gaci_pkg::FIELD_W;

  // Layout of the per-cell context that travels beside the arithmetic.
  localparam int unsigned O_EARLY = 0;
  localparam int unsigned O_CRUST = 1;
  localparam int unsigned O_S     = 2;
  localparam int unsigned O_ZC    = O_S + W;
  localparam int unsigned O_DTH   = O_ZC + W;
  localparam int unsigned O_KS    = O_DTH + W;
  localparam int unsigned O_KC    = O_KS + W;
  localparam int unsigned O_DT    = O_KC + W;
  localparam int unsigned O_V     = O_DT + W;
  localparam int unsigned O_H     = O_V + W;
  localparam int unsigned CTXW    = O_H + W;
  localparam int unsigned KCW     = CTXW + W;

  function automatic logic [W-1:0] to_word(logic [FW-1:0] x);
    logic [FW+W-1:0] t;
    t = (FW+W)'(x);
    return t[W-1:0];
  endfunction

  function automatic logic [FW-1:0] to_field(logic [W-1:0] x);
    logic [FW+W-1:0] t;
    t = (FW+W)'(x);
    return t[FW-1:0];
  endfunction

  function automatic logic [W-1:0] fx_add(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? '1 : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fx_sub(logic [W-1:0] a, logic [W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  logic en;

  // Configuration registers.
  logic [W-1:0] max_rate_q, early_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q  <= '0;
      early_thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gaci_pkg::cfg_idx_e'(cfg_idx_i))
        gaci_pkg::CFG_MAX_RATE:  max_rate_q  <= to_word(cfg_data_i);
        gaci_pkg::CFG_EARLY_THR: early_thr_q <= to_word(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a held result is being stalled.
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Input stage: mask the fields, flag early infiltration and form Psi + h.
  logic            v0_q;
  logic [CTXW-1:0] c0_d, c0_q;

  always_comb begin
    logic [W-1:0] h, v, psi;
    h   = to_word(in_data_i.water_depth);
    v   = to_word(in_data_i.infiltrated_total);
    psi = to_word(in_data_i.suction_head);
    c0_d = {h, v,
            to_word(in_data_i.time_step),
            to_word(in_data_i.crust_conductivity),
            to_word(in_data_i.soil_conductivity),
            to_word(in_data_i.moisture_deficit),
            to_word(in_data_i.crust_thickness),
            fx_add(psi, h),
            1'b0,
            (v <= early_thr_q)};
  end

  // Product zc * dth decides whether the wetting front is still inside the crust.
  logic            v1;
  logic [W-1:0]    m1;
  logic [CTXW-1:0] c1;

  gaci_mul #(.W(W), .F(FRAC_BITS), .SB(CTXW)) u_mul_crust (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v0_q), .a_i(c0_q[O_ZC +: W]), .b_i(c0_q[O_DTH +: W]), .side_i(c0_q),
    .vld_o(v1), .p_o(m1), .side_o(c1)
  );

  logic            v2_q;
  logic [CTXW-1:0] c2_d, c2_q;

  always_comb begin
    c2_d          = c1;
    c2_d[O_CRUST] = (c1[O_V +: W] <= m1);
  end

  // Wetting front depth Zf = V / dth.
  logic            v3;
  logic [W-1:0]    zf3;
  logic [CTXW-1:0] c3;

  gaci_div #(.W(W), .F(FRAC_BITS), .SB(CTXW)) u_div_zf (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v2_q), .a_i(c2_q[O_V +: W]), .b_i(c2_q[O_DTH +: W]), .side_i(c2_q),
    .vld_o(v3), .q_o(zf3), .side_o(c3)
  );

  logic            v4_q;
  logic [W-1:0]    diff4_q, zf4_q;
  logic [CTXW-1:0] c4_q;

  // Resistances of the soil below the crust and of the crust itself, side by side.
  logic            v5a, v5b;
  logic [W-1:0]    d1, d2, zf5;
  logic [CTXW-1:0] c5;

  gaci_div #(.W(W), .F(FRAC_BITS), .SB(W)) u_div_soil (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v4_q), .a_i(diff4_q), .b_i(c4_q[O_KS +: W]), .side_i(zf4_q),
    .vld_o(v5a), .q_o(d1), .side_o(zf5)
  );

  gaci_div #(.W(W), .F(FRAC_BITS), .SB(CTXW)) u_div_crust (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v4_q), .a_i(c4_q[O_ZC +: W]), .b_i(c4_q[O_KC +: W]), .side_i(c4_q),
    .vld_o(v5b), .q_o(d2), .side_o(c5)
  );

  logic            v6_q;
  logic [W-1:0]    den6_q, zf6_q;
  logic [CTXW-1:0] c6_q;

  // Harmonic conductivity Zf / (summed resistances).
  logic            v7;
  logic [W-1:0]    kh7;
  logic [CTXW-1:0] c7;

  gaci_div #(.W(W), .F(FRAC_BITS), .SB(CTXW)) u_div_harm (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v6_q), .a_i(zf6_q), .b_i(den6_q), .side_i(c6_q),
    .vld_o(v7), .q_o(kh7), .side_o(c7)
  );

  logic            v8_q;
  logic [W-1:0]    k8_q;
  logic [CTXW-1:0] c8_q;

  // Capacity term ((K * (Psi + h)) * dth) / V.
  logic            v9, v10, v11;
  logic [W-1:0]    m2, m3, d3;
  logic [KCW-1:0]  kc9, kc10, kc11;

  gaci_mul #(.W(W), .F(FRAC_BITS), .SB(KCW)) u_mul_head (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v8_q), .a_i(k8_q), .b_i(c8_q[O_S +: W]), .side_i({k8_q, c8_q}),
    .vld_o(v9), .p_o(m2), .side_o(kc9)
  );

  gaci_mul #(.W(W), .F(FRAC_BITS), .SB(KCW)) u_mul_deficit (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v9), .a_i(m2), .b_i(kc9[O_DTH +: W]), .side_i(kc9),
    .vld_o(v10), .p_o(m3), .side_o(kc10)
  );

  gaci_div #(.W(W), .F(FRAC_BITS), .SB(KCW)) u_div_depth (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v10), .a_i(m3), .b_i(kc10[O_V +: W]), .side_i(kc10),
    .vld_o(v11), .q_o(d3), .side_o(kc11)
  );

  // Rate selection: maximum rate early on, else the clamped capacity.
  logic         v12_q;
  logic [W-1:0] rate12_d, rate12_q, dt12_q, h12_q;

  always_comb begin
    logic [W-1:0] cap_rate;
    cap_rate = fx_add(kc11[CTXW +: W], d3);
    if (kc11[O_EARLY] || (cap_rate > max_rate_q)) begin
      rate12_d = max_rate_q;
    end else begin
      rate12_d = cap_rate;
    end
  end

  // Infiltration capacity of this step, rate * dt.
  logic         v13;
  logic [W-1:0] cap13, h13;

  gaci_mul #(.W(W), .F(FRAC_BITS), .SB(W)) u_mul_step (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(v12_q), .a_i(rate12_q), .b_i(dt12_q), .side_i(h12_q),
    .vld_o(v13), .p_o(cap13), .side_o(h13)
  );

  gaci_pkg::out_item_t out_d, out_q;

  always_comb begin
    if (h13 <= cap13) begin
      out_d.infiltrated     = to_field(h13);
      out_d.remaining_depth = '0;
    end else begin
      out_d.infiltrated     = to_field(cap13);
      out_d.remaining_depth = to_field(h13 - cap13);
    end
  end

  // Valid bits of the single-register stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v2_q        <= 1'b0;
      v4_q        <= 1'b0;
      v6_q        <= 1'b0;
      v8_q        <= 1'b0;
      v12_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= in_valid_i;
      v2_q        <= v1;
      v4_q        <= v3;
      v6_q        <= v5a && v5b;
      v8_q        <= v7;
      v12_q       <= v11;
      out_valid_q <= v13;
    end
  end

  // Payload of the single-register stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q     <= c0_d;
      c2_q     <= c2_d;
      diff4_q  <= fx_sub(zf3, c3[O_ZC +: W]);
      zf4_q    <= zf3;
      c4_q     <= c3;
      den6_q   <= fx_add(d1, d2);
      zf6_q    <= zf5;
      c6_q     <= c5;
      k8_q     <= c7[O_CRUST] ? c7[O_KC +: W] : kh7;
      c8_q     <= c7;
      rate12_q <= rate12_d;
      dt12_q   <= kc11[O_DT +: W];
      h12_q    <= kc11[O_H +: W];
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/gaci_mul.sv
// Three-stage saturating fixed-point multiplier with a side channel that travels along.
module gaci_mul #(
  parameter int unsigned W  = gaci_pkg::WORD_BITS_DEF,
  parameter int unsigned F  = gaci_pkg::FRAC_BITS_DEF,
  parameter int unsigned SB = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  b_i,
  input  logic [SB-1:0] side_i,
  output logic          vld_o,
  output logic [W-1:0]  p_o,
  output logic [SB-1:0] side_o
);

  localparam int unsigned LW = W / 2;
  localparam int unsigned HW = W - LW;
  localparam int unsigned PW = 2 * W;

  logic [2:0]       vld_q;
  logic [2*HW-1:0]  p00_q, p01_q, p10_q, p11_q;
  logic [SB-1:0]    side1_q, side2_q, side3_q;
  logic [PW-1:0]    prod_d, prod_q;
  logic [W-1:0]     res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Sum of the partial products of the low and high halves.
  always_comb begin
    prod_d = PW'(p00_q) + (PW'(p01_q) << LW) + (PW'(p10_q) << LW) + (PW'(p11_q) << (2 * LW));
  end

  always_comb begin
    if (prod_q[PW-1:W+F] != '0) begin
      res_d = '1;
    end else begin
      res_d = prod_q[W+F-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q   <= (2*HW)'(a_i[LW-1:0] * b_i[LW-1:0]);
      p01_q   <= (2*HW)'(a_i[LW-1:0] * b_i[W-1:LW]);
      p10_q   <= (2*HW)'(a_i[W-1:LW] * b_i[LW-1:0]);
      p11_q   <= (2*HW)'(a_i[W-1:LW] * b_i[W-1:LW]);
      side1_q <= side_i;
      prod_q  <= prod_d;
      side2_q <= side1_q;
      res_q   <= res_d;
      side3_q <= side2_q;
    end
  end

  assign vld_o  = vld_q[2];
  assign p_o    = res_q;
  assign side_o = side3_q;

endmodule

FILE: sv/gaci_div.sv
// Pipelined restoring divider for saturating fixed-point quotients, one quotient bit per stage.
module gaci_div #(
  parameter int unsigned W  = gaci_pkg::WORD_BITS_DEF,
  parameter int unsigned F  = gaci_pkg::FRAC_BITS_DEF,
  parameter int unsigned SB = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  b_i,
  input  logic [SB-1:0] side_i,
  output logic          vld_o,
  output logic [W-1:0]  q_o,
  output logic [SB-1:0] side_o
);

  localparam int unsigned SH = W - F;

  logic [W:0]    vld_q;
  logic [W-1:0]  r_d [0:W];
  logic [W-1:0]  r_q [0:W];
  logic [W-1:0]  l_d [0:W];
  logic [W-1:0]  l_q [0:W];
  logic [W-1:0]  q_d [0:W];
  logic [W-1:0]  q_q [0:W];
  logic [W-1:0]  b_q [0:W];
  logic          ovf_d;
  logic [W:0]    ovf_q;
  logic [SB-1:0] side_q [0:W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W-1:0], vld_i};
    end
  end

  // The dividend is a shifted left by F. Its top F bits form the first
  // partial remainder; the quotient overflows exactly when that is not below b.
  always_comb begin
    logic [W:0]   rx;
    logic [W+1:0] diff;
    r_d[0] = W'(a_i >> SH);
    l_d[0] = a_i << F;
    q_d[0] = '0;
    ovf_d  = (b_i == '0) || (W'(a_i >> SH) >= b_i);
    for (int i = 1; i <= W; i++) begin
      rx   = {r_q[i-1], l_q[i-1][W-1]};
      diff = {1'b0, rx} - {2'b00, b_q[i-1]};
      l_d[i] = l_q[i-1] << 1;
      if (!diff[W+1]) begin
        r_d[i] = diff[W-1:0];
        q_d[i] = {q_q[i-1][W-2:0], 1'b1};
      end else begin
        r_d[i] = rx[W-1:0];
        q_d[i] = {q_q[i-1][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q[0]    <= b_i;
      ovf_q[0]  <= ovf_d;
      side_q[0] <= side_i;
      for (int i = 0; i <= W; i++) begin
        r_q[i] <= r_d[i];
        l_q[i] <= l_d[i];
        q_q[i] <= q_d[i];
      end
      for (int i = 1; i <= W; i++) begin
        b_q[i]    <= b_q[i-1];
        ovf_q[i]  <= ovf_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign vld_o  = vld_q[W];
  assign q_o    = ovf_q[W] ? '1 : q_q[W];
  assign side_o = side_q[W];

endmodule

FILE: bench/green_ampt_crust_infiltration_core_test.sv
// Self-checking testbench for the Green-Ampt crust infiltration core.
`timescale 1ns / 100ps

module green_ampt_crust_infiltration_core_test;

  // Unsigned Q16.32 constants for the 48-bit word.
  localparam logic [47:0] VMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE = 48'h1_0000_0000;
  // Idle time after a drain, long enough to cover the depth of the pipeline.
  localparam int SETTLE = 260;
  localparam int LIMIT = 400000;
  localparam int RAND_ITEMS = 450;

  // One row of the directed table. When has_exp is set, the expected result is typed in.
  typedef struct {
    gaci_pkg::in_item_t d;
    bit has_exp;
    gaci_pkg::out_item_t e;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gaci_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [gaci_pkg::FIELD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  gaci_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  gaci_pkg::out_item_t out_data;

  // The predictor keeps its own copy of the two configuration registers.
  logic [47:0] rate_limit = '0;
  logic [47:0] early_depth = '0;

  gaci_pkg::out_item_t pending_splits[$];
  int mismatches = 0;
  int cycles = 0;
  bit steady_flow = 1'b0;
  bit hold_request = 1'b0;
  stim_row_t rows[$];

  green_ampt_crust_infiltration_core DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Fixed-point helpers. Products, quotients and sums saturate at the largest value.
  function automatic logic [47:0] q_mul(logic [47:0] a, logic [47:0] b);
    logic [127:0] p;
    p = ({80'd0, a} * {80'd0, b}) >> 32;
    return (p > {80'd0, VMAX}) ? VMAX : p[47:0];
  endfunction

  function automatic logic [47:0] q_div(logic [47:0] a, logic [47:0] b);
    logic [127:0] q;
    if (b == '0) return VMAX;
    q = ({80'd0, a} << 32) / {80'd0, b};
    return (q > {80'd0, VMAX}) ? VMAX : q[47:0];
  endfunction

  function automatic logic [47:0] q_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? VMAX : s[47:0];
  endfunction

  function automatic logic [47:0] q_sub(logic [47:0] a, logic [47:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Works out how a cell's water splits into infiltration and runoff.
  function automatic gaci_pkg::out_item_t split_water(gaci_pkg::in_item_t c);
    logic [47:0] cond, front, denom, rate, cap;
    gaci_pkg::out_item_t r;
    if (c.infiltrated_total <= early_depth) begin
      rate = rate_limit;
    end else begin
      if (c.infiltrated_total <= q_mul(c.crust_thickness, c.moisture_deficit)) begin
        // The wetting front is still inside the crust.
        cond = c.crust_conductivity;
      end else begin
        front = q_div(c.infiltrated_total, c.moisture_deficit);
        denom = q_add(q_div(q_sub(front, c.crust_thickness), c.soil_conductivity),
                      q_div(c.crust_thickness, c.crust_conductivity));
        cond = q_div(front, denom);
      end
      rate = q_add(cond, q_div(q_mul(q_mul(cond, q_add(c.suction_head, c.water_depth)),
                                     c.moisture_deficit), c.infiltrated_total));
      if (rate > rate_limit) rate = rate_limit;
    end
    cap = q_mul(rate, c.time_step);
    if (c.water_depth <= cap) begin
      r.infiltrated = c.water_depth;
      r.remaining_depth = '0;
    end else begin
      r.infiltrated = cap;
      r.remaining_depth = c.water_depth - cap;
    end
    return r;
  endfunction

  function automatic logic [47:0] any_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return VMAX;
      2: return w[47:0] >> $urandom_range(0, 47);
      default: return w[47:0];
    endcase
  endfunction

  // A plausible soil value: up to 2^scale in Q16.32, with a random fraction.
  function automatic logic [47:0] soil_word(int scale);
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0] >> (48 - 32 - scale + $urandom_range(0, 6));
  endfunction

  function automatic gaci_pkg::in_item_t random_cell();
    gaci_pkg::in_item_t c;
    if ($urandom_range(0, 9) < 7) begin
      // Well-formed cell, mostly past the early phase so the capacity path is exercised.
      c.water_depth = soil_word(3);
      c.infiltrated_total = q_add(early_depth, soil_word(2) + 48'd1);
      c.time_step = soil_word(0);
      c.crust_conductivity = soil_word(-2);
      c.soil_conductivity = soil_word(0);
      c.moisture_deficit = soil_word(-1);
      c.suction_head = soil_word(2);
      c.crust_thickness = soil_word(1);
      if ($urandom_range(0, 15) == 0) c.soil_conductivity = '0;
      if ($urandom_range(0, 15) == 0) c.crust_conductivity = '0;
      if ($urandom_range(0, 15) == 0) c.moisture_deficit = '0;
    end else begin
      c = {any_word(), any_word(), any_word(), any_word(),
           any_word(), any_word(), any_word(), any_word()};
    end
    return c;
  endfunction

  // One register write, with the write enable dropped again before the task returns.
  task automatic write_reg(gaci_pkg::cfg_idx_e idx, logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gaci_pkg::CFG_MAX_RATE) rate_limit = value;
    else early_depth = value;
    @(posedge clk);
  endtask

  // Offers one request after a random gap and waits until the core takes it.
  task automatic offer(gaci_pkg::in_item_t c, bit typed, gaci_pkg::out_item_t typed_split);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    pending_splits.push_back(typed ? typed_split : split_water(c));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) steady_flow = ~steady_flow;
      offer(random_cell(), 1'b0, '0);
    end
    steady_flow = 1'b0;
    drain();
  endtask

  // Receiver: stalls a random number of cycles before each result, and once for a long
  // stretch so that the pipeline fills and pushes back on the sender.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (700) @(posedge clk);
        hold_request = 1'b0;
      end
      wait_n = steady_flow ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_request);
    end
  end

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    gaci_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_splits.pop_front();
        if (out_data.infiltrated !== want.infiltrated ||
            out_data.remaining_depth !== want.remaining_depth) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: infiltrated exp %h got %h, remaining exp %h got %h",
                     want.infiltrated, out_data.infiltrated,
                     want.remaining_depth, out_data.remaining_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    // Rows 0..3 run with the reset configuration: zero rate, so nothing infiltrates.
    r.has_exp = 1'b1;
    r.d = '0; r.d.water_depth = VMAX; r.e = {48'd0, VMAX}; rows.push_back(r);
    r.d = '0; r.e = '0; rows.push_back(r);
    r.d = {8{VMAX}}; r.e = {48'd0, VMAX}; rows.push_back(r);
    r.d = '0; r.d.water_depth = 48'd1; r.d.infiltrated_total = 48'd5; r.e = {48'd0, 48'd1};
    rows.push_back(r);
    // From row 4 on, the rate limit is the largest value and there is no early phase.
    r.d = '0; r.d.water_depth = 5 * ONE; r.d.time_step = ONE; r.e = {5 * ONE, 48'd0};
    rows.push_back(r);
    r.has_exp = 1'b0;
    // Wetting front inside the crust.
    r.d = {2 * ONE, ONE / 8, ONE / 60, ONE / 100, ONE / 10, ONE / 4, 2 * ONE, ONE};
    rows.push_back(r);
    // Front below the crust, harmonic conductivity.
    r.d = {2 * ONE, 4 * ONE, ONE / 60, ONE / 100, ONE / 10, ONE / 4, 2 * ONE, ONE / 2};
    rows.push_back(r);
    // Zero soil conductivity.
    r.d.soil_conductivity = '0; rows.push_back(r);
    // Zero crust conductivity.
    r.d.soil_conductivity = ONE / 10; r.d.crust_conductivity = '0; rows.push_back(r);
    // Zero moisture deficit.
    r.d.crust_conductivity = ONE / 100; r.d.moisture_deficit = '0; rows.push_back(r);
    // Front just past the crust.
    r.d = {ONE, ONE / 4 + 48'd1, ONE, ONE / 100, ONE / 10, ONE / 4, ONE, ONE};
    rows.push_back(r);
    // Saturating sums and products.
    r.d = {8{VMAX}}; rows.push_back(r);
    r.d = {VMAX, 48'd1, VMAX, VMAX, 48'd1, VMAX, VMAX, 48'd0}; rows.push_back(r);
    r.d = {48'd0, VMAX, ONE, ONE, ONE, ONE, ONE, ONE}; rows.push_back(r);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < rows.size(); i++) begin
      if (i == 4) begin
        drain();
        write_reg(gaci_pkg::CFG_MAX_RATE, VMAX);
        write_reg(gaci_pkg::CFG_EARLY_THR, '0);
      end
      offer(rows[i].d, rows[i].has_exp, rows[i].e);
    end
    drain();

    // Random phases under different settings, the extremes among them.
    random_phase(RAND_ITEMS / 10);
    write_reg(gaci_pkg::CFG_MAX_RATE, soil_word(1));
    write_reg(gaci_pkg::CFG_EARLY_THR, soil_word(1));
    random_phase(RAND_ITEMS / 10);
    write_reg(gaci_pkg::CFG_MAX_RATE, ONE / 2);
    write_reg(gaci_pkg::CFG_EARLY_THR, VMAX);
    random_phase(RAND_ITEMS / 10);
    write_reg(gaci_pkg::CFG_MAX_RATE, '0);
    write_reg(gaci_pkg::CFG_EARLY_THR, '0);
    random_phase(RAND_ITEMS / 10);
    write_reg(gaci_pkg::CFG_MAX_RATE, any_word());
    write_reg(gaci_pkg::CFG_EARLY_THR, ONE / 4);
    // Long receiver hold while the sender keeps offering more requests than the
    // pipeline holds, so the core has to stall its input.
    hold_request = 1'b1;
    steady_flow = 1'b1;
    repeat (RAND_ITEMS / 2) offer(random_cell(), 1'b0, '0);
    steady_flow = 1'b0;
    drain();
    write_reg(gaci_pkg::CFG_MAX_RATE, VMAX);
    write_reg(gaci_pkg::CFG_EARLY_THR, soil_word(0));
    random_phase(RAND_ITEMS / 10);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
